/* hw/rtl/dlpd_pkg.sv */
`default_nettype none
package dlpd_pkg;

  // parse phases
  typedef enum logic [3:0] {
    PH_OPC      = 4'd0,
    PH_EXT_LEN  = 4'd1,
    PH_EXT_SUB  = 4'd2,
    PH_SET_ADDR = 4'd3,
    PH_SKIP     = 4'd4,
    PH_ULEB     = 4'd5,
    PH_SLEB     = 4'd6,
    PH_FIX2     = 4'd7,
    PH_SKIP_LEB = 4'd8
  } phase_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE, ST_DECODE, ST_DIV, ST_MUL, ST_APPLY, ST_OUT
  } state_t;

  // register indexes
  localparam logic [2:0] REG_MIN_INST = 3'd0;
  localparam logic [2:0] REG_LN_BASE  = 3'd1;
  localparam logic [2:0] REG_LN_RANGE = 3'd2;
  localparam logic [2:0] REG_OPC_BASE = 3'd3;
  localparam logic [2:0] REG_UNK_LEN  = 3'd4;

  // row kinds
  localparam logic [1:0] KIND_ROW   = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_TRUNC = 2'd2;

  // standard opcodes
  localparam logic [7:0] OP_EXTENDED  = 8'd0;
  localparam logic [7:0] OP_COPY      = 8'd1;
  localparam logic [7:0] OP_ADV_PC    = 8'd2;
  localparam logic [7:0] OP_ADV_LINE  = 8'd3;
  localparam logic [7:0] OP_SET_FILE  = 8'd4;
  localparam logic [7:0] OP_SET_COL   = 8'd5;
  localparam logic [7:0] OP_NEG_STMT  = 8'd6;
  localparam logic [7:0] OP_BASIC_BLK = 8'd7;
  localparam logic [7:0] OP_CONST_ADD = 8'd8;
  localparam logic [7:0] OP_FIXED_ADV = 8'd9;

  // extended sub-opcodes
  localparam logic [7:0] EXT_END_SEQ  = 8'd1;
  localparam logic [7:0] EXT_SET_ADDR = 8'd2;
  localparam logic [7:0] EXT_DEF_FILE = 8'd3;

  localparam int unsigned MAX_OPCODE_BASE = 26;
  localparam logic [7:0] SPECIAL_TOP = 8'd255;

  // what decode of a byte needs next
  typedef enum logic [1:0] {
    ACT_NONE, ACT_SPECIAL, ACT_CONST_ADD, ACT_ADV_PC
  } act_t;

  // datapath -> controller
  typedef struct packed {
    logic  need_div;   // special / const_add_pc: divide then scale
    logic  need_mul;   // advance_pc: scale only
    logic  div_done;
    logic  emit;       // byte produced a result
    logic  skip;       // byte ignored (after end)
  } dp_status_t;

  // controller -> datapath
  typedef struct packed {
    logic decode;   // take input byte
    logic div_step;
    logic mul;
    logic apply;
  } dp_cmd_t;

endpackage
`default_nettype wire

/* hw/rtl/dwarf2_line_program_decoder.sv */
`default_nettype none
// DWARF 2 line-number program decoder.
// s_axis: one program byte per word. tdata = data_byte; tuser = first_byte
// (restart: address 0, line 1, file 1); tlast = last_byte (end of section).
// m_axis: one row word. tdata = {row_file, row_line, row_address}, row_address at
// bit 0; tuser = row_kind (0 row, 1 end of sequence, 2 ended without it).
// cfg: write channel, cfg_index selects the register, cfg_data the value;
// write only while idle.
// Each byte passes the controller states accept, decode, then apply; plain
// bytes go straight from decode to apply; advance_pc adds a multiply state;
// special opcodes and const_add_pc run an 8-bit bit-serial divider by the
// line range, then the multiply. A byte that yields a row then holds it in
// the output register until m_axis_tready; no new byte is taken meanwhile.
// Bytes after an end are dropped after decode, without apply, until one with
// first_byte.
// Synchronous reset restores the register defaults and the start state.
module dwarf2_line_program_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // data_byte
  input  wire logic        s_axis_tuser,   // first_byte
  input  wire logic        s_axis_tlast,   // last_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [95:0]      m_axis_tdata,   // row_address, row_line, row_file
  output logic [1:0]       m_axis_tuser,   // row_kind
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);
  import dlpd_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t st;
  logic [31:0] ra, rl, rf;

  assign cfg_ready = 1'b1;

  dlpd_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .st, .cmd
  );

  dlpd_datapath u_dp (
    .clk, .rst,
    .data_byte(s_axis_tdata), .first_byte(s_axis_tuser), .last_byte(s_axis_tlast),
    .cfg_we(cfg_valid), .cfg_index, .cfg_data,
    .cmd, .st,
    .row_address(ra), .row_line(rl), .row_file(rf), .row_kind(m_axis_tuser)
  );

  assign m_axis_tdata = {rf, rl, ra};
endmodule
`default_nettype wire

/* hw/rtl/dlpd_ctrl.sv */
`default_nettype none
module dlpd_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire dlpd_pkg::dp_status_t st,
  output dlpd_pkg::dp_cmd_t      cmd
);
  import dlpd_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_DECODE;
      ST_DECODE: begin
        if (st.skip) state_next = ST_IDLE;
        else if (st.need_div) state_next = ST_DIV;
        else if (st.need_mul) state_next = ST_MUL;
        else state_next = ST_APPLY;
      end
      ST_DIV:    if (st.div_done) state_next = ST_MUL;
      ST_MUL:    state_next = ST_APPLY;
      ST_APPLY:  state_next = st.emit ? ST_OUT : ST_IDLE;
      ST_OUT:    if (out_ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = (state == ST_IDLE);
    out_valid = (state == ST_OUT);
    cmd = '0;
    case (state)
      ST_IDLE:   cmd.decode = in_valid;
      ST_DIV:    cmd.div_step = 1'b1;
      ST_MUL:    cmd.mul = 1'b1;
      ST_APPLY:  cmd.apply = 1'b1;
      default:   ;
    endcase
  end

  a_one_hot_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.decode, cmd.div_step, cmd.mul, cmd.apply}))
    else $error("several datapath commands");
  a_out_after_apply: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_APPLY))
    else $error("result without apply");
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input taken while result pending");
endmodule
`default_nettype wire

/* hw/rtl/dlpd_datapath.sv */
`default_nettype none
module dlpd_datapath (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [7:0]        data_byte,
  input  wire logic              first_byte,
  input  wire logic              last_byte,
  input  wire logic              cfg_we,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [63:0]       cfg_data,
  input  wire dlpd_pkg::dp_cmd_t cmd,
  output dlpd_pkg::dp_status_t   st,
  output logic [31:0]            row_address,
  output logic [31:0]            row_line,
  output logic [31:0]            row_file,
  output logic [1:0]             row_kind
);
  import dlpd_pkg::*;

  // configuration
  logic [7:0]  min_inst_length, ln_base, ln_range;
  logic [4:0]  opc_base;
  logic [63:0] unk_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_inst_length <= 8'd1;
      ln_base <= 8'hFB;
      ln_range <= 8'd14;
      opc_base <= 5'd10;
      unk_len <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_INST: min_inst_length <= cfg_data[7:0];
        REG_LN_BASE:  ln_base <= cfg_data[7:0];
        REG_LN_RANGE: ln_range <= cfg_data[7:0];
        REG_OPC_BASE: opc_base <= cfg_data[4:0];
        REG_UNK_LEN:  unk_len <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [7:0] eff_base, eff_range;
  always_comb begin
    if (opc_base < 5'd10) eff_base = 8'd10;
    else if (opc_base > 5'(MAX_OPCODE_BASE)) eff_base = 8'(MAX_OPCODE_BASE);
    else eff_base = {3'd0, opc_base};
    eff_range = (ln_range == 8'd0) ? 8'd1 : ln_range;
  end

  // decoder state
  phase_t      phase;
  logic [7:0]  held_opcode;
  logic [31:0] leb_accum;
  logic [5:0]  leb_shift;
  logic [31:0] bytes_to_skip;
  logic [3:0]  operands_left;
  logic [1:0]  fix_idx;
  logic [31:0] address_reg, line_reg, file_reg;
  logic        ended;
  act_t        act;
  logic        pend_row, pend_end, pend_last;

  // divider: 8-bit restoring, one quotient bit per cycle
  logic [7:0]  div_q, div_r, div_n;
  logic [3:0]  div_cnt;
  logic [9:0]  div_trial;
  logic [31:0] prod;

  // restart view of the registers when first_byte is set
  phase_t      c_phase;
  logic [31:0] c_accum, c_addr, c_line, c_file, c_skip;
  logic [5:0]  c_shift;
  logic [3:0]  c_ops;
  logic [1:0]  c_fix;
  logic        c_ended;

  always_comb begin
    if (first_byte) begin
      c_phase = PH_OPC; c_accum = '0; c_shift = '0; c_skip = '0;
      c_ops = '0; c_fix = '0; c_addr = '0; c_line = 32'd1; c_file = 32'd1;
      c_ended = 1'b0;
    end else begin
      c_phase = phase; c_accum = leb_accum; c_shift = leb_shift;
      c_skip = bytes_to_skip; c_ops = operands_left; c_fix = fix_idx;
      c_addr = address_reg; c_line = line_reg; c_file = file_reg;
      c_ended = ended;
    end
  end

  // LEB helpers
  logic [31:0] leb_or, leb_new;
  logic [5:0]  shift_new;
  logic [31:0] rest, sext_mask;
  logic [7:0]  adj;
  logic [5:0]  nib_sh;
  always_comb begin
    leb_or = (c_shift < 6'd32) ? ({25'd0, data_byte[6:0]} << c_shift[4:0]) : '0;
    leb_new = c_accum | leb_or;
    shift_new = (c_shift > 6'd56) ? 6'd63 : c_shift + 6'd7;
    sext_mask = (shift_new < 6'd32 && data_byte[6]) ? (32'hFFFFFFFF << shift_new[4:0])
                                                    : 32'd0;
    rest = c_skip - 32'd1;
    adj = data_byte - eff_base;
    nib_sh = {data_byte[3:0] - 4'd10, 2'b00};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_OPC; held_opcode <= '0; leb_accum <= '0; leb_shift <= '0;
      bytes_to_skip <= '0; operands_left <= '0; fix_idx <= '0;
      address_reg <= '0; line_reg <= 32'd1; file_reg <= 32'd1; ended <= 1'b0;
      act <= ACT_NONE; pend_row <= 1'b0; pend_end <= 1'b0; pend_last <= 1'b0;
      div_cnt <= '0;
    end else begin
      if (cmd.decode) begin
        act <= ACT_NONE; pend_row <= 1'b0; pend_end <= 1'b0; pend_last <= 1'b0;
        phase <= c_phase; leb_accum <= c_accum; leb_shift <= c_shift;
        bytes_to_skip <= c_skip; operands_left <= c_ops; fix_idx <= c_fix;
        address_reg <= c_addr; line_reg <= c_line; file_reg <= c_file;
        ended <= c_ended;
        div_n <= (data_byte == OP_CONST_ADD) ? SPECIAL_TOP - eff_base : adj;
        div_q <= '0; div_r <= '0; div_cnt <= 4'd8;
        if (!c_ended) begin
          pend_last <= last_byte;
          case (c_phase)
            PH_OPC: begin
              held_opcode <= data_byte;
              if (data_byte == OP_EXTENDED) begin
                leb_accum <= '0; leb_shift <= '0; phase <= PH_EXT_LEN;
              end else if (data_byte == OP_COPY) pend_row <= 1'b1;
              else if (data_byte == OP_ADV_PC || data_byte == OP_SET_FILE ||
                       data_byte == OP_SET_COL) begin
                leb_accum <= '0; leb_shift <= '0; phase <= PH_ULEB;
              end else if (data_byte == OP_ADV_LINE) begin
                leb_accum <= '0; leb_shift <= '0; phase <= PH_SLEB;
              end else if (data_byte == OP_NEG_STMT || data_byte == OP_BASIC_BLK) begin
              end else if (data_byte == OP_CONST_ADD) act <= ACT_CONST_ADD;
              else if (data_byte == OP_FIXED_ADV) begin
                leb_accum <= '0; leb_shift <= '0; fix_idx <= '0; phase <= PH_FIX2;
              end else if (data_byte < eff_base) begin
                operands_left <= unk_len[nib_sh +: 4];
                if (unk_len[nib_sh +: 4] != 4'd0) begin
                  leb_accum <= '0; leb_shift <= '0; phase <= PH_SKIP_LEB;
                end
              end else begin
                act <= ACT_SPECIAL; pend_row <= 1'b1;
              end
            end
            PH_EXT_LEN: begin
              leb_accum <= leb_new; leb_shift <= shift_new;
              if (!data_byte[7]) begin
                bytes_to_skip <= leb_new;
                phase <= (leb_new == 32'd0) ? PH_OPC : PH_EXT_SUB;
              end
            end
            PH_EXT_SUB: begin
              if (data_byte == EXT_END_SEQ) begin
                phase <= PH_OPC; pend_end <= 1'b1;
              end else if (data_byte == EXT_SET_ADDR) begin
                bytes_to_skip <= (rest > 32'd4) ? rest - 32'd4 : 32'd0;
                fix_idx <= '0; leb_accum <= '0; leb_shift <= '0; phase <= PH_SET_ADDR;
              end else begin
                bytes_to_skip <= rest;
                phase <= (rest == 32'd0) ? PH_OPC : PH_SKIP;
              end
            end
            PH_SET_ADDR: begin
              leb_accum <= c_accum | ({24'd0, data_byte} << {c_fix, 3'b000});
              if (c_fix == 2'd3) begin
                address_reg <= c_accum | ({24'd0, data_byte} << 24);
                fix_idx <= '0;
                phase <= (c_skip == 32'd0) ? PH_OPC : PH_SKIP;
              end else fix_idx <= c_fix + 2'd1;
            end
            PH_SKIP: begin
              if (c_skip <= 32'd1) begin
                bytes_to_skip <= '0; phase <= PH_OPC;
              end else bytes_to_skip <= rest;
            end
            PH_ULEB: begin
              leb_accum <= leb_new; leb_shift <= shift_new;
              if (!data_byte[7]) begin
                phase <= PH_OPC;
                if (held_opcode == OP_ADV_PC) act <= ACT_ADV_PC;
                else if (held_opcode == OP_SET_FILE) file_reg <= leb_new;
              end
            end
            PH_SLEB: begin
              leb_accum <= leb_new; leb_shift <= shift_new;
              if (!data_byte[7]) begin
                line_reg <= c_line + (leb_new | sext_mask);
                phase <= PH_OPC;
              end
            end
            PH_FIX2: begin
              leb_accum <= c_accum | ({24'd0, data_byte} << {c_fix[0], 3'b000});
              if (c_fix[0]) begin
                address_reg <= c_addr + {16'd0, data_byte, c_accum[7:0]};
                fix_idx <= '0; phase <= PH_OPC;
              end else fix_idx <= 2'd1;
            end
            PH_SKIP_LEB: begin
              if (!data_byte[7]) begin
                operands_left <= c_ops - 4'd1;
                if (c_ops == 4'd1) phase <= PH_OPC;
              end
            end
            default: phase <= PH_OPC;
          endcase
        end
      end
      // divider step; the shifted remainder can reach 9 bits
      if (cmd.div_step && div_cnt != 4'd0) begin
        div_r <= div_trial[9] ? {div_r[6:0], div_n[7]} : div_trial[7:0];
        div_q <= {div_q[6:0], ~div_trial[9]};
        div_n <= {div_n[6:0], 1'b0};
        div_cnt <= div_cnt - 4'd1;
      end
      if (cmd.mul) prod <= 32'((act == ACT_ADV_PC ? leb_accum : {24'd0, div_q})
                               * {24'd0, min_inst_length});
      if (cmd.apply) begin
        if (act != ACT_NONE) address_reg <= address_reg + prod;
        if (act == ACT_SPECIAL)
          line_reg <= line_reg + {{24{ln_base[7]}}, ln_base} + {24'd0, div_r};
        if (pend_end || pend_last) begin
          ended <= 1'b1; phase <= PH_OPC;
        end
        row_kind <= pend_end ? KIND_END : (pend_last ? KIND_TRUNC : KIND_ROW);
      end
    end
  end

  assign div_trial = {1'b0, div_r, div_n[7]} - {2'b00, eff_range};

  assign row_address = address_reg;
  assign row_line = line_reg;
  assign row_file = file_reg;

  always_comb begin
    st = '0;
    st.skip = ended;
    st.need_div = (act == ACT_SPECIAL) || (act == ACT_CONST_ADD);
    st.need_mul = (act == ACT_ADV_PC);
    st.div_done = (div_cnt == 4'd1);
    st.emit = pend_row || pend_end || pend_last;
  end

  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    (cmd.mul && act != ACT_ADV_PC) |-> (div_r < eff_range))
    else $error("divider remainder out of range");
  a_end_sets: assert property (@(posedge clk) disable iff (rst)
    (cmd.apply && pend_end) |=> ended && row_kind == KIND_END)
    else $error("end of sequence not latched");
  a_phase_reset: assert property (@(posedge clk) disable iff (rst)
    ended |-> phase == PH_OPC)
    else $error("phase left after end");
endmodule
`default_nettype wire

/* test/dwarf2_line_program_decoder_test.sv */
`timescale 1ns / 1ps
module dwarf2_line_program_decoder_test;
  import dlpd_pkg::*;

  localparam int IDLE_MAX = 15;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
  } prog_byte_t;

  typedef struct packed {
    logic [31:0] address;
    logic [31:0] line;
    logic [31:0] file;
    logic [1:0]  kind;
  } line_row_t;

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = '0;
  logic s_axis_tuser = 0;
  logic s_axis_tlast = 0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [95:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  dwarf2_line_program_decoder u_top (.*);

  always #5 clk = ~clk;

  // Decoder shadow: configuration and state
  logic [7:0]  sh_min_inst, sh_ln_base, sh_ln_range;
  logic [4:0]  sh_opc_base;
  logic [63:0] sh_unk_len;
  phase_t      sh_phase;
  logic [7:0]  sh_opcode;
  logic [31:0] sh_accum, sh_skip, sh_addr, sh_line, sh_file;
  logic [5:0]  sh_shift;
  logic [3:0]  sh_operands;
  logic [1:0]  sh_fix_idx;
  logic        sh_ended;

  prog_byte_t pending_bytes[$];
  line_row_t  expected_rows[$];
  int errors = 0, rows_seen = 0, bytes_sent = 0, gen_count = 0;
  bit stim_done = 0;
  int watchdog = 0;

  function automatic void restart_regs();
    sh_phase = PH_OPC; sh_opcode = 0; sh_accum = 0; sh_shift = 0; sh_skip = 0;
    sh_operands = 0; sh_fix_idx = 0; sh_addr = 0; sh_line = 1; sh_file = 1;
    sh_ended = 0;
  endfunction

  function automatic logic [31:0] eff_base();
    if (sh_opc_base < 10) return 10;
    if (sh_opc_base > MAX_OPCODE_BASE) return MAX_OPCODE_BASE;
    return sh_opc_base;
  endfunction

  function automatic logic [31:0] eff_range();
    return (sh_ln_range == 0) ? 32'd1 : {24'd0, sh_ln_range};
  endfunction

  function automatic bit leb_take(logic [7:0] b);
    if (sh_shift < 32) sh_accum |= {25'd0, b[6:0]} << sh_shift;
    sh_shift = (sh_shift + 7 > 63) ? 6'd63 : sh_shift + 6'd7;
    return !b[7];
  endfunction

  function automatic void leb_clear(phase_t nxt);
    sh_accum = 0; sh_shift = 0; sh_phase = nxt;
  endfunction

  // 0 nothing, 1 row, 2 end of sequence
  function automatic int decode_byte(logic [7:0] b);
    logic [31:0] base, adj, r, rest;
    base = eff_base(); r = eff_range();
    case (sh_phase)
      PH_OPC: begin
        sh_opcode = b;
        if (b == OP_EXTENDED) begin leb_clear(PH_EXT_LEN); return 0; end
        if (b == OP_COPY) return 1;
        if (b == OP_ADV_PC || b == OP_SET_FILE || b == OP_SET_COL) begin
          leb_clear(PH_ULEB); return 0;
        end
        if (b == OP_ADV_LINE) begin leb_clear(PH_SLEB); return 0; end
        if (b == OP_NEG_STMT || b == OP_BASIC_BLK) return 0;
        if (b == OP_CONST_ADD) begin
          sh_addr += ((32'(SPECIAL_TOP) - base) / r) * sh_min_inst; return 0;
        end
        if (b == OP_FIXED_ADV) begin leb_clear(PH_FIX2); sh_fix_idx = 0; return 0; end
        if (b < base) begin
          sh_operands = 4'(sh_unk_len >> (((b - 10) * 4) & 63));
          if (sh_operands != 0) leb_clear(PH_SKIP_LEB);
          return 0;
        end
        adj = b - base;
        sh_addr += (adj / r) * sh_min_inst;
        sh_line += {{24{sh_ln_base[7]}}, sh_ln_base} + adj % r;
        return 1;
      end
      PH_EXT_LEN: begin
        if (leb_take(b)) begin
          sh_skip = sh_accum;
          sh_phase = (sh_skip == 0) ? PH_OPC : PH_EXT_SUB;
        end
      end
      PH_EXT_SUB: begin
        rest = sh_skip - 1;
        if (b == EXT_END_SEQ) begin sh_phase = PH_OPC; return 2; end
        if (b == EXT_SET_ADDR) begin
          sh_skip = rest > 4 ? rest - 4 : 0; sh_fix_idx = 0; leb_clear(PH_SET_ADDR);
        end else begin
          sh_skip = rest; sh_phase = rest == 0 ? PH_OPC : PH_SKIP;
        end
      end
      PH_SET_ADDR: begin
        sh_accum |= {24'd0, b} << (sh_fix_idx * 8);
        if (sh_fix_idx == 3) begin
          sh_addr = sh_accum; sh_fix_idx = 0;
          sh_phase = sh_skip == 0 ? PH_OPC : PH_SKIP;
        end else sh_fix_idx++;
      end
      PH_SKIP: begin
        if (sh_skip <= 1) begin sh_skip = 0; sh_phase = PH_OPC; end
        else sh_skip--;
      end
      PH_ULEB: begin
        if (leb_take(b)) begin
          if (sh_opcode == OP_ADV_PC) sh_addr += sh_accum * sh_min_inst;
          else if (sh_opcode == OP_SET_FILE) sh_file = sh_accum;
          sh_phase = PH_OPC;
        end
      end
      PH_SLEB: begin
        if (leb_take(b)) begin
          if (sh_shift < 32 && b[6]) sh_accum |= 32'hFFFFFFFF << sh_shift;
          sh_line += sh_accum; sh_phase = PH_OPC;
        end
      end
      PH_FIX2: begin
        sh_accum |= {24'd0, b} << (sh_fix_idx[0] * 8);
        if (sh_fix_idx >= 1) begin
          sh_addr += sh_accum & 32'hFFFF; sh_fix_idx = 0; sh_phase = PH_OPC;
        end else sh_fix_idx = 1;
      end
      PH_SKIP_LEB: begin
        if (!b[7]) begin
          sh_operands--;
          if (sh_operands == 0) sh_phase = PH_OPC;
        end
      end
      default: sh_phase = PH_OPC;
    endcase
    return 0;
  endfunction

  // Advance the shadow by one accepted byte, queueing any row it yields
  function automatic void predict_row(prog_byte_t pb);
    int r;
    line_row_t row;
    if (pb.first) restart_regs();
    if (sh_ended) return;
    r = decode_byte(pb.data);
    row.address = sh_addr; row.line = sh_line; row.file = sh_file;
    if (r == 2) begin
      sh_ended = 1; sh_phase = PH_OPC; row.kind = KIND_END;
    end else if (pb.last) begin
      sh_ended = 1; sh_phase = PH_OPC; row.kind = KIND_TRUNC;
    end else if (r == 1) row.kind = KIND_ROW;
    else return;
    expected_rows.push_back(row);
  endfunction

  // Driver
  int send_wait = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_row('{s_axis_tdata, s_axis_tuser, s_axis_tlast});
        bytes_sent++;
        send_wait = ($urandom_range(3) == 0) ? 0 : $urandom_range(IDLE_MAX);
      end
      if (send_wait > 0) begin
        send_wait--;
        s_axis_tvalid <= 0;
      end else if ((!s_axis_tvalid || s_axis_tready) && pending_bytes.size() > 0) begin
        prog_byte_t pb;
        pb = pending_bytes.pop_front();
        s_axis_tvalid <= 1;
        {s_axis_tdata, s_axis_tuser, s_axis_tlast} <= pb;
      end else if (s_axis_tvalid && s_axis_tready) s_axis_tvalid <= 0;
    end
  end

  // Monitor and checker
  int recv_wait = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        line_row_t exp_row;
        rows_seen++;
        if (expected_rows.size() == 0) begin
          $error("unexpected row %h kind %0d", m_axis_tdata, m_axis_tuser);
          errors++;
        end else begin
          exp_row = expected_rows.pop_front();
          if (m_axis_tdata[31:0] !== exp_row.address) begin
            $error("row_address exp %h got %h", exp_row.address, m_axis_tdata[31:0]);
            errors++;
          end
          if (m_axis_tdata[63:32] !== exp_row.line) begin
            $error("row_line exp %h got %h", exp_row.line, m_axis_tdata[63:32]);
            errors++;
          end
          if (m_axis_tdata[95:64] !== exp_row.file) begin
            $error("row_file exp %h got %h", exp_row.file, m_axis_tdata[95:64]);
            errors++;
          end
          if (m_axis_tuser !== exp_row.kind) begin
            $error("row_kind exp %0d got %0d", exp_row.kind, m_axis_tuser);
            errors++;
          end
        end
        recv_wait = ($urandom_range(3) == 0) ? 0 : $urandom_range(IDLE_MAX);
      end
      if (recv_wait > 0) begin
        recv_wait--;
        m_axis_tready <= 0;
      end else m_axis_tready <= 1;
    end
  end

  // Watchdog on stalled handshakes
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready) || rst)
      watchdog <= 0;
    else if (pending_bytes.size() > 0 || expected_rows.size() > 0 || s_axis_tvalid ||
             !s_axis_tready || cfg_valid) begin
      watchdog <= watchdog + 1;
      if (watchdog >= WATCHDOG_LIMIT) begin
        $display("timeout waiting for handshake");
        $display("dwarf2_line_program_decoder_test: FAIL");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    case (idx)
      REG_MIN_INST: sh_min_inst = val[7:0];
      REG_LN_BASE:  sh_ln_base = val[7:0];
      REG_LN_RANGE: sh_ln_range = val[7:0];
      REG_OPC_BASE: sh_opc_base = val[4:0];
      default:      sh_unk_len = val;
    endcase
  endtask

  // Wait for the block to drain before touching configuration;
  // sampled on the falling edge so driver updates have settled
  task automatic drain();
    while (pending_bytes.size() > 0 || s_axis_tvalid || !s_axis_tready ||
           expected_rows.size() > 0)
      @(negedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic void put(logic [7:0] d, bit f = 0, bit l = 0);
    pending_bytes.push_back('{d, f, l});
    gen_count++;
  endfunction

  function automatic void put_uleb(logic [31:0] v, int pad = 0);
    do begin
      put({(v > 127 || pad > 0), v[6:0]});
      v = v >> 7;
    end while (v != 0);
    while (pad > 0) begin
      pad--;
      put({pad > 0, 7'h00});
    end
  endfunction

  function automatic void put_sleb(int v);
    bit more;
    do begin
      logic [7:0] b;
      b = {1'b0, v[6:0]};
      v = v >>> 7;
      more = !((v == 0 && !b[6]) || (v == -1 && b[6]));
      put({more, b[6:0]});
    end while (more);
  endfunction

  // A well-formed sequence with random content, closed by end of sequence or sometimes by a last byte
  function automatic void put_sequence(int n);
    put(OP_COPY, 1);
    repeat (n) begin
      case ($urandom_range(11))
        0: put(OP_COPY);
        1: begin
          put(OP_ADV_PC);
          put_uleb($urandom_range(3) == 0 ? $urandom : $urandom_range(200));
        end
        2: begin
          put(OP_ADV_LINE);
          put_sleb($urandom_range(1) ? int'($urandom) : $urandom_range(40) - 20);
        end
        3: begin put(OP_SET_FILE); put_uleb($urandom_range(20)); end
        4: begin put(OP_SET_COL); put_uleb($urandom_range(300)); end
        5: put($urandom_range(1) ? OP_NEG_STMT : OP_CONST_ADD);
        6: begin put(OP_FIXED_ADV); put(8'($urandom)); put(8'($urandom)); end
        7: begin
          int extra = $urandom_range(2);
          put(OP_EXTENDED); put_uleb(5 + extra); put(EXT_SET_ADDR);
          repeat (4 + extra) put(8'($urandom));
        end
        8: begin
          int len = $urandom_range(3);
          put(OP_EXTENDED); put_uleb(len);
          if (len > 0) begin put(EXT_DEF_FILE); repeat (len - 1) put(8'($urandom)); end
        end
        9: begin
          put(8'($urandom_range(10, 25)));
          repeat ($urandom_range(3)) put_uleb($urandom_range(1000));
        end
        default: put(8'($urandom_range(10, 255)));
      endcase
    end
    if ($urandom_range(7) == 0) put(8'($urandom), 0, 1);
    else begin put(OP_EXTENDED); put_uleb(1); put(EXT_END_SEQ); put(8'($urandom)); end
  endfunction

  // Random byte noise, sometimes with restart or last flags
  function automatic void put_noise(int n);
    repeat (n) put(8'($urandom), $urandom_range(9) == 0, $urandom_range(15) == 0);
  endfunction

  task automatic random_phase(int target);
    int goal;
    goal = gen_count + target;
    while (gen_count < goal) begin
      if ($urandom_range(4) == 0) put_noise($urandom_range(1, 12));
      else put_sequence($urandom_range(1, 20));
    end
    drain();
  endtask

  initial begin
    sh_min_inst = 1; sh_ln_base = 8'hFB; sh_ln_range = 14; sh_opc_base = 10;
    sh_unk_len = 0;
    restart_regs();
    repeat (2) @(posedge clk);
    rst <= 0;

    // Directed: every opcode, extremes and special cases at reset settings
    put(OP_COPY, 1); put(OP_CONST_ADD); put(8'd10); put(8'd255);
    put(OP_ADV_PC); put_uleb(32'hFFFFFFFF); put(OP_ADV_LINE); put_sleb(-3);
    put(OP_ADV_LINE); put_sleb(5);
    put(OP_SET_FILE); put_uleb(7, 5);         // long LEB beyond 32 bits
    put(OP_FIXED_ADV); put(8'hFF); put(8'hFF);
    put(OP_EXTENDED); put_uleb(0);            // empty extended opcode
    put(OP_EXTENDED); put_uleb(7); put(EXT_SET_ADDR);
    put(8'h78); put(8'h56); put(8'h34); put(8'h12); put(8'hAA); put(8'hBB);
    put(OP_NEG_STMT); put(OP_BASIC_BLK); put(OP_SET_COL); put(8'h80, 0, 1);
    put(OP_COPY);                              // ignored after end
    put(OP_COPY, 1, 1);                        // row on final byte
    put(OP_EXTENDED, 1); put(8'd3); put(EXT_END_SEQ); put(8'h11); put(8'h22);
    put(8'd16, 1); put(8'd200); put(8'd0, 0, 1);
    drain();

    // Settings: extremes and random values; all registers written
    write_reg(REG_MIN_INST, 255); write_reg(REG_LN_BASE, 8'h80);
    write_reg(REG_LN_RANGE, 255); write_reg(REG_OPC_BASE, 26);
    write_reg(REG_UNK_LEN, 64'hFEDCBA9876543210);
    random_phase(380);
    write_reg(REG_MIN_INST, 1); write_reg(REG_LN_BASE, 8'h7F);
    write_reg(REG_LN_RANGE, 1); write_reg(REG_OPC_BASE, 31);
    write_reg(REG_UNK_LEN, 64'hFFFFFFFFFFFFFFFF);
    random_phase(380);
    write_reg(REG_LN_RANGE, 0); write_reg(REG_OPC_BASE, 3);
    write_reg(REG_UNK_LEN, 64'h0123456789ABCDEF);
    random_phase(380);
    repeat (2) begin
      write_reg(REG_MIN_INST, $urandom_range(1, 255));
      write_reg(REG_LN_BASE, $urandom);
      write_reg(REG_LN_RANGE, $urandom_range(1, 255));
      write_reg(REG_OPC_BASE, $urandom_range(10, 26));
      write_reg(REG_UNK_LEN, {$urandom, $urandom});
      random_phase(380);
    end

    repeat (50) @(posedge clk);
    if (expected_rows.size() > 0) begin
      $error("%0d rows never arrived", expected_rows.size());
      errors++;
    end
    $display("Sent %0d program bytes under the reset and five further register settings;",
             bytes_sent);
    $display("checked %0d rows.", rows_seen);
    if (errors == 0) $display("dwarf2_line_program_decoder_test: PASS");
    else $display("dwarf2_line_program_decoder_test: FAIL");
    $finish;
  end
endmodule
